@@ rtl/strict_priority_multi_ring_queue_core_macros.svh @@
// assertion macros for the strict priority multi ring queue
`ifndef STRICT_PRIORITY_MULTI_RING_QUEUE_CORE_MACROS_SVH
`define STRICT_PRIORITY_MULTI_RING_QUEUE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define SPRQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define SPRQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/sprq_pkg.sv @@
// shared constants, codes and control types of the priority ring queue
package sprq_pkg;

	localparam int CLASSES_DEF      = 4;
	localparam int DEPTH_DEF        = 16;
	localparam int PAYLOAD_BITS_DEF = 32;

	localparam int CLASS_W  = 2;
	localparam int EVENT_W  = 32;
	localparam int STATUS_W = 2;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	localparam logic [STATUS_W-1:0] STATUS_PUSHED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL   = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_POPPED = 2'd2;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd3;

	typedef struct packed {
		logic load_item;
		logic exec;
		logic load_read;
	} ctl_cmd_t;

	typedef struct packed {
		logic needs_read;
		logic out_full;
	} dp_status_t;

endpackage

@@ rtl/sprq_in_if.sv @@
// request channel: push or pop command with class and payload
interface sprq_in_if;
	import sprq_pkg::*;

	logic               valid;
	logic               ready;
	logic               opcode;
	logic [CLASS_W-1:0] event_class;
	logic [EVENT_W-1:0] event_payload;

	modport source (output valid, output opcode, output event_class, output event_payload,
		input ready);
	modport sink (input valid, input opcode, input event_class, input event_payload,
		output ready);
endinterface

@@ rtl/sprq_out_if.sv @@
// response channel: status and popped event
interface sprq_out_if;
	import sprq_pkg::*;

	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [CLASS_W-1:0]  popped_class;
	logic [EVENT_W-1:0]  popped_payload;

	modport source (output valid, output status, output popped_class, output popped_payload,
		input ready);
	modport sink (input valid, input status, input popped_class, input popped_payload,
		output ready);
endinterface

@@ rtl/sprq_ram.sv @@
// generic single write port ram with registered read
module sprq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

@@ rtl/sprq_ctrl.sv @@
// controller: sequences accept, execute and ram read of one item at a time
module sprq_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sprq_pkg::dp_status_t st,
	output sprq_pkg::ctl_cmd_t   cmd
);
	import sprq_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_READ = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	always_comb begin
		state_d       = state_q;
		in_ready      = 1'b0;
		cmd.load_item = 1'b0;
		cmd.exec      = 1'b0;
		cmd.load_read = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = !st.out_full;
				if (in_valid && !st.out_full) begin
					cmd.load_item = 1'b1;
					state_d       = ST_EXEC;
				end
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				state_d  = st.needs_read ? ST_READ : ST_IDLE;
			end
			ST_READ: begin
				cmd.load_read = 1'b1;
				state_d       = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

@@ rtl/sprq_dp.sv @@
// datapath: ring pointers, priority pick, ring storage and result register
module sprq_dp #(
	parameter int CLASSES      = sprq_pkg::CLASSES_DEF,
	parameter int DEPTH        = sprq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = sprq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sprq_pkg::ctl_cmd_t           cmd,
	output sprq_pkg::dp_status_t         st,
	input  logic                         opcode,
	input  logic [sprq_pkg::CLASS_W-1:0] event_class,
	input  logic [sprq_pkg::EVENT_W-1:0] event_payload,
	sprq_out_if.source                   rsp
);
	import sprq_pkg::*;

	localparam int CW        = (CLASSES > 1) ? $clog2(CLASSES) : 1;
	localparam int PW        = $clog2(DEPTH);
	localparam int AW        = CW + PW;
	localparam int RAM_DEPTH = 1 << AW;

	function automatic logic [PW-1:0] ptr_adv(input logic [PW-1:0] ptr);
		ptr_adv = (ptr == PW'(DEPTH - 1)) ? '0 : ptr + 1'b1;
	endfunction

	logic               op_q;
	logic [CLASS_W-1:0] cls_q;
	logic [EVENT_W-1:0] payload_q;

	logic [PW-1:0] head_q [CLASSES];
	logic [PW-1:0] tail_q [CLASSES];

	logic [CLASSES-1:0] nonempty;
	logic               hit;
	logic [CW-1:0]      pidx;
	logic [CW-1:0]      cls_idx;
	logic               cls_ok;
	logic [PW-1:0]      tail_nxt;
	logic               ring_full;
	logic               push_ok;
	logic               pop_ok;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr;
	logic [AW-1:0]           ram_raddr;
	logic [PAYLOAD_BITS-1:0] ram_wdata;
	logic [PAYLOAD_BITS-1:0] ram_rdata;

	logic                out_valid_q;
	logic [STATUS_W-1:0] status_q;
	logic [CLASS_W-1:0]  pclass_q;
	logic [EVENT_W-1:0]  ppayload_q;

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q      <= opcode;
			cls_q     <= event_class;
			payload_q <= event_payload;
		end
	end

	// lowest numbered non-empty ring wins
	always_comb begin
		hit  = 1'b0;
		pidx = '0;
		for (int i = 0; i < CLASSES; i++) begin
			nonempty[i] = head_q[i] != tail_q[i];
		end
		for (int i = CLASSES - 1; i >= 0; i--) begin
			if (nonempty[i]) begin
				hit  = 1'b1;
				pidx = CW'(i);
			end
		end
	end

	assign cls_ok    = {3'b000, cls_q} < 5'(CLASSES);
	assign cls_idx   = CW'(cls_q);
	assign tail_nxt  = ptr_adv(tail_q[cls_idx]);
	assign ring_full = cls_ok && (tail_nxt == head_q[cls_idx]);
	assign push_ok   = (op_q == OP_PUSH) && cls_ok && !ring_full;
	assign pop_ok    = (op_q == OP_POP) && hit;

	assign ram_we    = cmd.exec && push_ok;
	assign ram_waddr = {cls_idx, tail_q[cls_idx]};
	assign ram_wdata = PAYLOAD_BITS'(payload_q);
	assign ram_raddr = {pidx, head_q[pidx]};

	sprq_ram #(
		.WIDTH(PAYLOAD_BITS),
		.DEPTH(RAM_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.exec && pop_ok),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CLASSES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (cmd.exec) begin
			if (push_ok) begin
				tail_q[cls_idx] <= tail_nxt;
			end
			if (pop_ok) begin
				head_q[pidx] <= ptr_adv(head_q[pidx]);
			end
		end
	end

	// result register, freed by the response transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((cmd.exec && !pop_ok) || cmd.load_read) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			pclass_q   <= '0;
			ppayload_q <= '0;
			if (op_q == OP_PUSH) begin
				status_q <= push_ok ? STATUS_PUSHED : STATUS_FULL;
			end else if (hit) begin
				status_q <= STATUS_POPPED;
				pclass_q <= CLASS_W'(pidx);
			end else begin
				status_q <= STATUS_EMPTY;
			end
		end else if (cmd.load_read) begin
			ppayload_q <= EVENT_W'(ram_rdata);
		end
	end

	assign st.needs_read = pop_ok;
	assign st.out_full   = out_valid_q && !rsp.ready;

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = status_q;
	assign rsp.popped_class   = pclass_q;
	assign rsp.popped_payload = ppayload_q;
endmodule

@@ rtl/strict_priority_multi_ring_queue_core.sv @@
// top level of the strict priority multi ring event queue
// sequence: every request but a pop that hits answers once ST_EXEC has registered its result, a pop that
// hits answers after ST_READ as well (the extra state for the registered ring storage read)
// flow: one item in flight, a new request is taken only in ST_IDLE with the result register free or draining
// reset: arst_n clears all head and tail pointers, so every ring starts empty; the
// ring storage is not cleared and needs no clearing pass
`include "strict_priority_multi_ring_queue_core_macros.svh"

module strict_priority_multi_ring_queue_core #(
	parameter int CLASSES      = sprq_pkg::CLASSES_DEF,
	parameter int DEPTH        = sprq_pkg::DEPTH_DEF,
	parameter int PAYLOAD_BITS = sprq_pkg::PAYLOAD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	sprq_in_if.sink    req,
	sprq_out_if.source rsp
);
	import sprq_pkg::*;

	ctl_cmd_t   cmd;
	dp_status_t st;
	logic       in_ready;

	sprq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(req.valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	sprq_dp #(
		.CLASSES     (CLASSES),
		.DEPTH       (DEPTH),
		.PAYLOAD_BITS(PAYLOAD_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.opcode       (req.opcode),
		.event_class  (req.event_class),
		.event_payload(req.event_payload),
		.rsp          (rsp)
	);

	assign req.ready = in_ready;

	// a new request only enters when the result register is free or draining
	`SPRQ_ASSERT_NOW(a_no_overrun, clk, arst_n, req.valid && req.ready, !rsp.valid || rsp.ready, "request accepted over a held result")
	// every accepted request is executed in the following cycle
	`SPRQ_ASSERT_NEXT(a_exec_follows, clk, arst_n, req.valid && req.ready, cmd.exec, "accepted request not executed")
	// ram data is captured only right after a pop that hit
	`SPRQ_ASSERT_NOW(a_read_after_pop, clk, arst_n, cmd.load_read, $past(cmd.exec && st.needs_read), "read capture without a preceding pop")
endmodule
